@@ rtl/core/product_counter_controller_defines.svh @@
// Assertion macros shared by the product counter controller RTL.
`ifndef PRODUCT_COUNTER_CONTROLLER_DEFINES_SVH
`define PRODUCT_COUNTER_CONTROLLER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/pcc_pkg.sv @@
// Types and constants shared by the product counter controller.
package pcc_pkg;

    localparam int unsigned TARGET_W      = 16;
    localparam int unsigned COUNT_W       = 16;
    localparam int unsigned TICK_W        = 16;
    localparam int unsigned SECONDS_W     = 6;
    localparam int unsigned MINUTES_W     = 7;
    localparam int unsigned LOCKOUT_W     = 8;
    localparam int unsigned OP_W          = 3;
    localparam int unsigned CFG_INDEX_W   = 2;
    localparam int unsigned CFG_DATA_W    = 16;

    localparam int unsigned SECONDS_PER_MINUTE     = 60;
    localparam int unsigned MINUTES_WRAP           = 100;
    localparam int unsigned RESET_TICKS_PER_SECOND = 1000;
    localparam int unsigned RESET_LOCKOUT          = 20;
    localparam int unsigned RESET_TARGET           = 20;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TICKS_PER_SECOND = 2'd0,
        REG_LOCKOUT_TICKS    = 2'd1
    } cfg_index_t;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_SENSOR     = 3'd1,
        OP_START      = 3'd2,
        OP_STOP       = 3'd3,
        OP_TOGGLE     = 3'd4,
        OP_RESET      = 3'd5,
        OP_SET_TARGET = 3'd6
    } op_code_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_TICK,
        CMD_SENSOR,
        CMD_START,
        CMD_STOP,
        CMD_TOGGLE,
        CMD_CLEAR,
        CMD_SET_TARGET
    } cmd_kind_t;

    typedef enum logic [1:0] {
        LS_PAUSE = 2'd0,
        LS_RUN   = 2'd1,
        LS_ALARM = 2'd2
    } line_state_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [TARGET_W-1:0] target;
    } cmd_t;

    typedef struct packed {
        line_state_t          line_state;
        logic [COUNT_W-1:0]   product_total;
        logic [MINUTES_W-1:0] minutes_run;
        logic [SECONDS_W-1:0] seconds_run;
        logic [TARGET_W-1:0]  target_now;
        logic                 refused;
        logic                 alarm_raised;
    } report_t;

endpackage

@@ rtl/core/pcc_channels.sv @@
// Stream interfaces for the event words and the report words.
interface pcc_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [15:0] new_target;

    modport source (output valid, output operation, output new_target, input ready);
    modport sink (input valid, input operation, input new_target, output ready);
endinterface

interface pcc_report_if;
    logic        valid;
    logic        ready;
    logic [1:0]  line_state;
    logic [15:0] product_total;
    logic [6:0]  minutes_run;
    logic [5:0]  seconds_run;
    logic [15:0] target_now;
    logic        refused;
    logic        alarm_raised;

    modport source (
        output valid, output line_state, output product_total, output minutes_run,
        output seconds_run, output target_now, output refused, output alarm_raised,
        input ready
    );
    modport sink (
        input valid, input line_state, input product_total, input minutes_run,
        input seconds_run, input target_now, input refused, input alarm_raised,
        output ready
    );
endinterface

@@ rtl/core/product_counter_controller.sv @@
// Top level of the production-line counter controller.
// One event word is accepted per clock cycle while the command queue has
// room, and each one yields exactly one report word. An accepted event first
// enters a short command queue, the back end updates the line state as it
// pops it, and the report is registered in an output register when the back
// end pops the command and is held there until it is taken. The back end's
// state update, done as each command is popped, sets the one-event-per-cycle
// rate; the queue and the output register let the event side keep going,
// until the queue is full, while a report waits to be taken. Configuration
// writes (ticks per second at index 0, sensor lockout at index 1) take effect
// on the next cycle and should be made while no event is in flight.
module product_counter_controller #(
    parameter int unsigned QUEUE_DEPTH = pcc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    pcc_event_if.sink                       events,
    pcc_report_if.source                    reports,
    input  logic                            write_enable,
    input  logic [pcc_pkg::CFG_INDEX_W-1:0] write_index,
    input  logic [pcc_pkg::CFG_DATA_W-1:0]  write_data
);
    import pcc_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_word;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_word;

    pcc_front u_front (
        .events     (events),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    pcc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    pcc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_word     (pop_word),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .reports      (reports)
    );

endmodule

@@ rtl/core/pcc_front.sv @@
// Front end: accepts event words and classifies them into commands.
module pcc_front (
    pcc_event_if.sink    events,
    output logic         push_valid,
    input  logic         push_ready,
    output pcc_pkg::cmd_t push_word
);
    import pcc_pkg::*;

    assign events.ready = push_ready;
    assign push_valid   = events.valid;

    always_comb
    begin
        push_word.target = events.new_target;
        case (events.operation)
            OP_TICK:       push_word.kind = CMD_TICK;
            OP_SENSOR:     push_word.kind = CMD_SENSOR;
            OP_START:      push_word.kind = CMD_START;
            OP_STOP:       push_word.kind = CMD_STOP;
            OP_TOGGLE:     push_word.kind = CMD_TOGGLE;
            OP_RESET:      push_word.kind = CMD_CLEAR;
            OP_SET_TARGET: push_word.kind = CMD_SET_TARGET;
            default:       push_word.kind = CMD_NONE;
        endcase
    end

endmodule

@@ rtl/core/pcc_queue.sv @@
// Short command queue between the front end and the back end.
module pcc_queue #(
    parameter int unsigned QUEUE_DEPTH = pcc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  pcc_pkg::cmd_t push_word,
    output logic          pop_valid,
    input  logic          pop_ready,
    output pcc_pkg::cmd_t pop_word
);
    import pcc_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    cmd_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (fill_reg != CNT_FULL);
    assign pop_valid  = (fill_reg != '0);
    assign pop_word   = entries_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entries_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

@@ rtl/core/pcc_back.sv @@
// Back end: line state, counters, configuration registers and the report register.
`include "product_counter_controller_defines.svh"

module pcc_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  pcc_pkg::cmd_t                    pop_word,
    input  logic                             write_enable,
    input  logic [pcc_pkg::CFG_INDEX_W-1:0]  write_index,
    input  logic [pcc_pkg::CFG_DATA_W-1:0]   write_data,
    pcc_report_if.source                     reports
);
    import pcc_pkg::*;

    localparam logic [SECONDS_W-1:0] SEC_WRAP = SECONDS_W'(SECONDS_PER_MINUTE);
    localparam logic [MINUTES_W-1:0] MIN_WRAP = MINUTES_W'(MINUTES_WRAP);

    logic [TICK_W-1:0]    tps_reg;
    logic [LOCKOUT_W-1:0] lockout_ticks_reg;

    logic                 running_reg,    running_next;
    logic                 alarm_reg,      alarm_next;
    logic [COUNT_W-1:0]   count_reg,      count_next;
    logic [TARGET_W-1:0]  target_reg,     target_next;
    logic [TICK_W-1:0]    tick_count_reg, tick_count_next;
    logic [SECONDS_W-1:0] seconds_reg,    seconds_next;
    logic [MINUTES_W-1:0] minutes_reg,    minutes_next;
    logic [LOCKOUT_W-1:0] lockout_reg,    lockout_next;
    logic                 out_valid_reg,  out_valid_next;
    report_t              report_reg,     report_next;

    logic [TICK_W-1:0]    tick_inc;
    logic [SECONDS_W-1:0] seconds_inc;
    logic [MINUTES_W-1:0] minutes_inc;
    logic                 pop_fire;
    logic                 refused;
    logic                 raised;

    assign pop_ready   = !out_valid_reg || reports.ready;
    assign pop_fire    = pop_valid && pop_ready;
    assign tick_inc    = tick_count_reg + 1'b1;
    assign seconds_inc = seconds_reg + 1'b1;
    assign minutes_inc = minutes_reg + 1'b1;

    always_comb
    begin
        running_next    = running_reg;
        alarm_next      = alarm_reg;
        count_next      = count_reg;
        target_next     = target_reg;
        tick_count_next = tick_count_reg;
        seconds_next    = seconds_reg;
        minutes_next    = minutes_reg;
        lockout_next    = lockout_reg;
        refused         = 1'b0;
        raised          = 1'b0;

        if (pop_fire)
        begin
            case (pop_word.kind)
                CMD_TICK:
                begin
                    if (running_reg)
                    begin
                        if (tick_inc >= tps_reg)
                        begin
                            tick_count_next = '0;
                            if (seconds_inc >= SEC_WRAP)
                            begin
                                seconds_next = '0;
                                minutes_next = (minutes_inc >= MIN_WRAP) ? '0 : minutes_inc;
                            end
                            else
                            begin
                                seconds_next = seconds_inc;
                            end
                        end
                        else
                        begin
                            tick_count_next = tick_inc;
                        end
                    end
                    if (lockout_reg != '0)
                    begin
                        lockout_next = lockout_reg - 1'b1;
                    end
                end
                CMD_SENSOR:
                begin
                    if (lockout_reg == '0)
                    begin
                        lockout_next = lockout_ticks_reg;
                        if (running_reg)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                CMD_START:
                begin
                    if (alarm_reg)
                    begin
                        refused = 1'b1;
                    end
                    else
                    begin
                        running_next = 1'b1;
                    end
                end
                CMD_STOP:
                begin
                    running_next = 1'b0;
                end
                CMD_TOGGLE:
                begin
                    if (alarm_reg)
                    begin
                        refused = 1'b1;
                    end
                    else
                    begin
                        running_next = !running_reg;
                    end
                end
                CMD_CLEAR:
                begin
                    count_next      = '0;
                    seconds_next    = '0;
                    minutes_next    = '0;
                    tick_count_next = '0;
                    alarm_next      = 1'b0;
                end
                CMD_SET_TARGET:
                begin
                    target_next = pop_word.target;
                    if (alarm_reg && (count_reg < pop_word.target))
                    begin
                        alarm_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase

            // A running line that has reached its target stops in alarm.
            if (running_next && (count_next >= target_next))
            begin
                running_next = 1'b0;
                alarm_next   = 1'b1;
                raised       = 1'b1;
            end
        end
    end

    always_comb
    begin
        report_next = report_reg;
        out_valid_next = out_valid_reg && !reports.ready;
        if (pop_fire)
        begin
            out_valid_next           = 1'b1;
            report_next.line_state   = alarm_next ? LS_ALARM : (running_next ? LS_RUN : LS_PAUSE);
            report_next.product_total = count_next;
            report_next.minutes_run  = minutes_next;
            report_next.seconds_run  = seconds_next;
            report_next.target_now   = target_next;
            report_next.refused      = refused;
            report_next.alarm_raised = raised;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg           <= TICK_W'(RESET_TICKS_PER_SECOND);
            lockout_ticks_reg <= LOCKOUT_W'(RESET_LOCKOUT);
        end
        else if (write_enable)
        begin
            case (write_index)
                REG_TICKS_PER_SECOND: tps_reg <= write_data[TICK_W-1:0];
                REG_LOCKOUT_TICKS:    lockout_ticks_reg <= write_data[LOCKOUT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            alarm_reg      <= 1'b0;
            count_reg      <= '0;
            target_reg     <= TARGET_W'(RESET_TARGET);
            tick_count_reg <= '0;
            seconds_reg    <= '0;
            minutes_reg    <= '0;
            lockout_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            running_reg    <= running_next;
            alarm_reg      <= alarm_next;
            count_reg      <= count_next;
            target_reg     <= target_next;
            tick_count_reg <= tick_count_next;
            seconds_reg    <= seconds_next;
            minutes_reg    <= minutes_next;
            lockout_reg    <= lockout_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        report_reg <= report_next;
    end

    assign reports.valid         = out_valid_reg;
    assign reports.line_state    = report_reg.line_state;
    assign reports.product_total = report_reg.product_total;
    assign reports.minutes_run   = report_reg.minutes_run;
    assign reports.seconds_run   = report_reg.seconds_run;
    assign reports.target_now    = report_reg.target_now;
    assign reports.refused       = report_reg.refused;
    assign reports.alarm_raised  = report_reg.alarm_raised;

    `PCC_ASSERT_NOW(a_run_alarm_excl, running_reg, !alarm_reg, "line runs while in alarm")
    `PCC_ASSERT_NOW(a_run_below_target, running_reg, count_reg < target_reg, "running at target")
    `PCC_ASSERT_NEXT(a_target_taken, pop_fire && (pop_word.kind == CMD_SET_TARGET), target_reg == $past(pop_word.target), "target not taken")
    `PCC_ASSERT_NOW(a_raised_state, out_valid_reg && report_reg.alarm_raised, report_reg.line_state == LS_ALARM, "raised without alarm")

endmodule
